/* sv/wvs_pkg.sv */
// ----------------------------------------------------------------------------
// wvs_pkg
// shared constants, operation and status codes, and the cell control bundle
// for the word vector stack
// ----------------------------------------------------------------------------
package wvs_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 64;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = IDX_W + 1;
  localparam int GROUPS    = 8;
  localparam int GRP_SIZE  = DEPTH / GROUPS;

  localparam logic [2:0] OP_PUSH     = 3'd0;
  localparam logic [2:0] OP_POP      = 3'd1;
  localparam logic [2:0] OP_POP_AT   = 3'd2;
  localparam logic [2:0] OP_PEEK     = 3'd3;
  localparam logic [2:0] OP_GET      = 3'd4;
  localparam logic [2:0] OP_SET      = 3'd5;
  localparam logic [2:0] OP_CONTAINS = 3'd6;
  localparam logic [2:0] OP_CLEAR    = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef struct packed {
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [WORD_BITS-1:0] word;
    logic                 shift;
    logic [IDX_W-1:0]     pos;
    logic [CNT_W-1:0]     cnt;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    logic                 search;
  } cell_ctl_t;

endpackage

/* sv/wvs_cell.sv */
// ----------------------------------------------------------------------------
// wvs_cell
// one storage cell of the stack chain: holds a word, takes a write, takes the
// word of its upper neighbor when a gap closes, and offers read and match
// ----------------------------------------------------------------------------
module wvs_cell
  import wvs_pkg::*;
(
  input  logic                 clk_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  cell_ctl_t            ctl_i,
  input  logic [WORD_BITS-1:0] nxt_i,
  output logic [WORD_BITS-1:0] data_o,
  output logic [WORD_BITS-1:0] rd_o,
  output logic                 hit_o
);

  logic [WORD_BITS-1:0] data_q;
  logic [WORD_BITS-1:0] data_d;
  logic [CNT_W-1:0]     idx_ext;
  logic                 in_use;
  logic                 shift_here;

  assign idx_ext    = {1'b0, idx_i};
  assign in_use     = idx_ext < ctl_i.cnt;
  assign shift_here = ctl_i.shift && (idx_i >= ctl_i.pos) &&
                      ((idx_ext + CNT_W'(1)) < ctl_i.cnt);

  always_comb begin
    data_d = data_q;
    if (ctl_i.wr_en && (idx_i == ctl_i.wr_idx)) begin
      data_d = ctl_i.word;
    end else if (shift_here) begin
      data_d = nxt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (ctl_i.rd_en && (idx_i == ctl_i.rd_idx)) ? data_q : '0;
  assign hit_o  = ctl_i.search && in_use && (data_q == ctl_i.word);

endmodule

/* sv/word_vector_stack_top.sv */
// ----------------------------------------------------------------------------
// word_vector_stack_top
// bounded word stack with indexed access, built as a chain of storage cells
//
// channel  dir  signals               contents
// s_axis   in   tvalid tready tdata   operation, position, word_in
// m_axis   out  tvalid tready tdata   word_out, found, status, count_out
//
// each transaction goes through capture, cell update with a registered
// partial read tree, and final read merge into the output register
// a new transaction is taken only while the sequencer is idle; the output
// register holds a result until it is taken, and the next one waits in the
// merge step if the output register is still occupied
// reset clears the count and the control; cell contents stay undefined
// ----------------------------------------------------------------------------
module word_vector_stack_top
  import wvs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [79:0] s_axis_tdata_i,  // operation[2:0] position[8:3] word_in[72:9]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o   // word_out[63:0] found[64] status[66:65] count_out[73:67]
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [2:0]           op_q;
  logic [IDX_W-1:0]     pos_q;
  logic [WORD_BITS-1:0] word_q;
  logic [1:0]           stat_q, stat_d;
  logic                 hit_q;
  logic [WORD_BITS-1:0] part_q [GROUPS];
  logic [WORD_BITS-1:0] part_d [GROUPS];
  logic                 out_vld_q;
  logic [79:0]          out_q;
  logic [WORD_BITS-1:0] rd_word;

  cell_ctl_t            ctl;
  logic [WORD_BITS-1:0] cell_data [DEPTH];
  logic [WORD_BITS-1:0] cell_rd   [DEPTH];
  logic [DEPTH-1:0]     cell_hit;

  logic                 in_acc;
  logic                 out_load;
  logic                 empty, full, in_rng;
  logic [IDX_W-1:0]     top_idx;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == S_FIN) && (!out_vld_q || m_axis_tready_i);

  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign in_rng  = {1'b0, pos_q} < cnt_q;
  assign top_idx = IDX_W'(cnt_q - CNT_W'(1));

  // operation decode, valid in the update cycle only
  always_comb begin
    ctl        = '0;
    ctl.word   = word_q;
    ctl.pos    = pos_q;
    ctl.cnt    = cnt_q;
    ctl.wr_idx = pos_q;
    ctl.rd_idx = pos_q;
    cnt_d      = cnt_q;
    stat_d     = STAT_OK;
    if (state_q == S_EXEC) begin
      unique case (op_q)
        OP_PUSH: begin
          if (full) begin
            stat_d = STAT_FULL;
          end else begin
            ctl.wr_en  = 1'b1;
            ctl.wr_idx = IDX_W'(cnt_q);
            cnt_d      = cnt_q + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (empty) begin
            stat_d = STAT_EMPTY;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = top_idx;
            cnt_d      = cnt_q - CNT_W'(1);
          end
        end
        OP_POP_AT: begin
          if (empty) begin
            stat_d = STAT_EMPTY;
          end else if (!in_rng) begin
            stat_d = STAT_RANGE;
          end else begin
            ctl.rd_en = 1'b1;
            ctl.shift = 1'b1;
            cnt_d     = cnt_q - CNT_W'(1);
          end
        end
        OP_PEEK: begin
          if (empty) begin
            stat_d = STAT_EMPTY;
          end else begin
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = top_idx;
          end
        end
        OP_GET: begin
          if (!in_rng) begin
            stat_d = STAT_RANGE;
          end else begin
            ctl.rd_en = 1'b1;
          end
        end
        OP_SET: begin
          if (!in_rng) begin
            stat_d = STAT_RANGE;
          end else begin
            ctl.wr_en = 1'b1;
          end
        end
        OP_CONTAINS: begin
          ctl.search = 1'b1;
        end
        OP_CLEAR: begin
          cnt_d = '0;
        end
        default: begin
          stat_d = STAT_OK;
        end
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] nxt;
    if (g == DEPTH - 1) begin : g_end
      assign nxt = cell_data[g];
    end else begin : g_mid
      assign nxt = cell_data[g+1];
    end
    wvs_cell u_cell (
      .clk_i  (clk_i),
      .idx_i  (IDX_W'(g)),
      .ctl_i  (ctl),
      .nxt_i  (nxt),
      .data_o (cell_data[g]),
      .rd_o   (cell_rd[g]),
      .hit_o  (cell_hit[g])
    );
  end

  // first level of the read tree
  always_comb begin
    for (int k = 0; k < GROUPS; k++) begin
      part_d[k] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        part_d[k] = part_d[k] | cell_rd[k*GRP_SIZE+j];
      end
    end
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < GROUPS; k++) begin
      rd_word = rd_word | part_q[k];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC:  state_d = S_FIN;
      S_FIN:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tdata_i[2:0];
      pos_q  <= s_axis_tdata_i[8:3];
      word_q <= s_axis_tdata_i[72:9];
    end
    if (state_q == S_EXEC) begin
      stat_q <= stat_d;
      hit_q  <= |cell_hit;
      part_q <= part_d;
    end
    if (out_load) begin
      out_q <= {6'd0, cnt_q, stat_q, hit_q, rd_word};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_exec_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_FIN)
    else $error("update step not followed by merge step");

  a_vld_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == S_FIN)
    else $error("result appeared outside merge step");

  a_hit_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && hit_q) |-> op_q == OP_CONTAINS)
    else $error("match flag on a non-search operation");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for word_vector_stack_top: a command stream with bursty
// gaps goes in, and every reply is compared field by field against a
// behavioral stack that is updated as each command is accepted
// ----------------------------------------------------------------------------
module tb;
  import wvs_pkg::*;

  localparam int STUCK_LIMIT = 20000;
  localparam int RAND_ITEMS  = 1700;

  typedef struct packed {
    logic [63:0] word;
    logic [5:0]  pos;
    logic [2:0]  op;
  } stack_cmd_t;

  typedef struct packed {
    logic [6:0]  count;
    logic [1:0]  status;
    logic        found;
    logic [63:0] word;
  } stack_reply_t;

  typedef struct {
    stack_cmd_t cmd;
    bit         wait_idle;
  } cmd_entry_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  cmd_entry_t   cmd_q[$];
  stack_reply_t reply_q[$];
  logic [63:0]  model_words [DEPTH];
  logic [6:0]   model_count = '0;
  logic [63:0]  word_pool [16];
  int           gen_count    = 0;
  int           items_sent   = 0;
  int           results_seen = 0;
  int           idle_cycles  = 0;
  int           errors       = 0;
  int           burst_left;
  int           gap_left;
  int           rx_mode;
  int           rx_left;
  int           hold_left;
  int           holds_done;
  logic         rx_go;
  logic         drained;
  stack_reply_t next_reply;
  stack_reply_t want_reply;
  stack_reply_t seen_reply;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  word_vector_stack_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  task automatic stack_model_step(input stack_cmd_t c, output stack_reply_t r);
    int i;
    r = '0;
    case (c.op)
      OP_PUSH: begin
        if (model_count >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          model_words[model_count] = c.word;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          model_count--;
          r.word = model_words[model_count];
        end
      end
      OP_POP_AT: begin
        if (model_count == 0) begin
          r.status = STAT_EMPTY;
        end else if (c.pos >= model_count) begin
          r.status = STAT_RANGE;
        end else begin
          r.word = model_words[c.pos];
          for (i = int'(c.pos); i + 1 < model_count; i++) model_words[i] = model_words[i + 1];
          model_count--;
        end
      end
      OP_PEEK: begin
        if (model_count == 0) r.status = STAT_EMPTY;
        else r.word = model_words[model_count - 1];
      end
      OP_GET: begin
        if (c.pos >= model_count) r.status = STAT_RANGE;
        else r.word = model_words[c.pos];
      end
      OP_SET: begin
        if (c.pos >= model_count) r.status = STAT_RANGE;
        else model_words[c.pos] = c.word;
      end
      OP_CONTAINS: begin
        for (i = 0; i < model_count; i++) begin
          if (model_words[i] == c.word) r.found = 1'b1;
        end
      end
      default: model_count = '0;
    endcase
    r.count = model_count;
  endtask

  task automatic add_cmd(input logic [2:0] op, input logic [5:0] pos, input logic [63:0] word,
                         input bit wait_idle);
    cmd_entry_t e;
    e.cmd.op     = op;
    e.cmd.pos    = pos;
    e.cmd.word   = word;
    e.wait_idle  = wait_idle;
    cmd_q.push_back(e);
    case (op)
      OP_PUSH:   if (gen_count < DEPTH) gen_count++;
      OP_POP:    if (gen_count > 0) gen_count--;
      OP_POP_AT: if (pos < gen_count) gen_count--;
      OP_CLEAR:  gen_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] pick_word();
    if ($urandom_range(0, 9) < 6) return word_pool[$urandom_range(0, 15)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [5:0] pick_pos();
    if (gen_count > 0 && $urandom_range(0, 9) < 8) return 6'($urandom_range(0, gen_count - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
      errors++;
    end
  endtask

  // command driver, bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
    end else begin
      drained = (items_sent + (s_axis_tvalid && s_axis_tready)) ==
                (results_seen + (m_axis_tvalid && m_axis_tready));
      if (s_axis_tvalid && s_axis_tready) begin
        stack_model_step(cmd_q[0].cmd, next_reply);
        reply_q.push_back(next_reply);
        void'(cmd_q.pop_front());
        items_sent <= items_sent + 1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0 && (!cmd_q[0].wait_idle || drained)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, cmd_q[0].cmd};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // reply sink, stall pattern changes every stretch, two long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_mode    = 0;
      rx_left    = 0;
      hold_left  = 0;
      holds_done = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(16, 120);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < 2 && results_seen >= 400 + holds_done * 700) begin
        hold_left = 300;
        holds_done++;
      end
      case (rx_mode)
        0: rx_go = 1'b1;
        1: rx_go = 1'($urandom_range(0, 1));
        2: rx_go = (rx_left % 4 == 0);
        default: rx_go = ($urandom_range(0, 7) != 0);
      endcase
      m_axis_tready <= rx_go && (hold_left == 0);
    end
  end

  // reply checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen <= results_seen + 1;
      if (reply_q.size() == 0) begin
        $display("%0t: reply with no pending transaction, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want_reply = reply_q.pop_front();
        seen_reply = m_axis_tdata[73:0];
        check_field("word_out", want_reply.word, seen_reply.word);
        check_field("found", 64'(want_reply.found), 64'(seen_reply.found));
        check_field("status", 64'(want_reply.status), 64'(seen_reply.status));
        check_field("count_out", 64'(want_reply.count), 64'(seen_reply.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    int         mode;
    int         len;
    int         k;
    int         n_gen;
    int         r;
    logic [2:0] op;

    for (k = 0; k < 16; k++) word_pool[k] = {$urandom, $urandom};
    word_pool[0] = '1;
    word_pool[1] = '0;

    // empty list corner cases
    add_cmd(OP_POP, 6'd0, '0, 1'b0);
    add_cmd(OP_PEEK, 6'd0, '0, 1'b0);
    add_cmd(OP_POP_AT, 6'd0, '0, 1'b0);
    add_cmd(OP_GET, 6'd0, '0, 1'b0);
    add_cmd(OP_SET, 6'd63, '1, 1'b0);
    add_cmd(OP_CONTAINS, 6'd0, '0, 1'b0);
    add_cmd(OP_CLEAR, 6'd0, '0, 1'b0);
    // word extremes, indexed access, search and gap closing
    add_cmd(OP_PUSH, 6'd0, '1, 1'b0);
    add_cmd(OP_PUSH, 6'd0, '0, 1'b0);
    add_cmd(OP_PUSH, 6'd0, 64'h8000_0000_0000_0001, 1'b0);
    add_cmd(OP_PUSH, 6'd0, 64'h5555_5555_5555_5555, 1'b0);
    add_cmd(OP_PUSH, 6'd0, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_cmd(OP_PEEK, 6'd0, '0, 1'b0);
    add_cmd(OP_GET, 6'd4, '0, 1'b0);
    add_cmd(OP_GET, 6'd5, '0, 1'b0);
    add_cmd(OP_SET, 6'd0, 64'h0123_4567_89ab_cdef, 1'b0);
    add_cmd(OP_CONTAINS, 6'd0, '1, 1'b0);
    add_cmd(OP_CONTAINS, 6'd0, 64'h1, 1'b0);
    add_cmd(OP_POP_AT, 6'd1, '0, 1'b0);
    add_cmd(OP_POP_AT, 6'd63, '0, 1'b0);
    add_cmd(OP_POP, 6'd0, '0, 1'b0);
    add_cmd(OP_POP_AT, 6'd0, '0, 1'b0);
    add_cmd(OP_CONTAINS, 6'd0, 64'h0123_4567_89ab_cdef, 1'b0);
    add_cmd(OP_CLEAR, 6'd0, '0, 1'b0);
    add_cmd(OP_CONTAINS, 6'd0, '1, 1'b0);

    // random phases: fill to full, drain to empty, indexed work, search, mix
    n_gen = 0;
    while (n_gen < RAND_ITEMS) begin
      mode = $urandom_range(0, 4);
      case (mode)
        0: len = $urandom_range(60, 100);
        1: len = $urandom_range(40, 90);
        2: len = $urandom_range(20, 60);
        3: len = $urandom_range(10, 40);
        default: len = $urandom_range(10, 30);
      endcase
      for (k = 0; k < len; k++) begin
        r = $urandom_range(0, 19);
        case (mode)
          0: op = (r != 0) ? OP_PUSH : 3'($urandom_range(0, 7));
          1: op = (r < 10) ? OP_POP : (r < 16) ? OP_POP_AT : 3'($urandom_range(0, 7));
          2: begin
            case (r % 5)
              0: op = OP_POP_AT;
              1: op = OP_GET;
              2: op = OP_SET;
              3: op = OP_PEEK;
              default: op = OP_PUSH;
            endcase
          end
          3: op = (r < 14) ? OP_CONTAINS : OP_PUSH;
          default: op = 3'($urandom_range(0, 7));
        endcase
        add_cmd(op, pick_pos(), pick_word(), (n_gen % 250) == 249);
        n_gen++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((cmd_q.size() != 0 || reply_q.size() != 0) && idle_cycles < STUCK_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
      errors++;
    end else begin
      repeat (10) @(posedge clk_i);
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
